FILE: rtl/core/tuf_pkg.sv
package tuf_pkg;

  typedef enum logic [2:0] {
    FMT_R8    = 3'd0,
    FMT_RGB8  = 3'd1,
    FMT_BGR8  = 3'd2,
    FMT_BGRA8 = 3'd3,
    FMT_RGBA8 = 3'd4,
    FMT_RG16F = 3'd5
  } pixel_format_e;

  localparam logic [2:0] FmtReset = 3'd4;

  typedef struct packed {
    logic [31:0] src_high;
    logic [31:0] src_low;
    logic        last_in;
  } src_t;

  typedef struct packed {
    logic [31:0] out_word;
    logic        last_out;
  } res_t;

  // Pre-rounding view of one half conversion.
  typedef struct packed {
    logic        sign;
    logic        zero;
    logic        inf;
    logic        sub;
    logic [4:0]  exp;
    logic [3:0]  shift;
    logic [23:0] mant;
  } half_pre_t;

  function automatic half_pre_t half_decode(input logic [31:0] bits);
    half_pre_t p;
    logic [8:0] e;
    e = {1'b0, bits[30:23]};
    p.sign  = bits[31];
    p.zero  = e < 9'd102;
    p.sub   = (e >= 9'd102) && (e <= 9'd112);
    p.inf   = e >= 9'd143;
    p.exp   = 5'(e - 9'd112);
    p.shift = 4'(9'd113 - e);
    p.mant  = {1'b1, bits[22:0]};
    return p;
  endfunction

endpackage

FILE: rtl/core/texel_upload_formatter.sv
// An accepted start reaches the done strobe through the valid registers v1_q, v2_q and v3_q of the half stage.
// Throughput: one texel per cycle; busy is held low.
// Reset: the pipeline empties and the format register returns to RGBA8.
// The receiver cannot stall; each result is shown for one cycle only.
module texel_upload_formatter (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  tuf_pkg::src_t src_i,
  output logic          done_o,
  output tuf_pkg::res_t res_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [2:0]    cfg_data_i
);
  import tuf_pkg::*;

  logic [2:0]  fmt_q;
  logic        acc;
  logic        v0, v1;
  logic [15:0] h0, h1;
  logic [31:0] w1_q, w2_q, w3_q;
  logic [2:0]  f1_q, f2_q, f3_q;
  logic        l1_q, l2_q, l3_q;
  logic [7:0]  b0, b1, b2, b3;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign acc         = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= FmtReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      fmt_q <= cfg_data_i;
    end
  end

  tuf_half_stage u_h0 (.clk_i, .rst_ni, .valid_i(acc), .bits_i(src_i.src_low),
                       .valid_o(v0), .half_o(h0));
  tuf_half_stage u_h1 (.clk_i, .rst_ni, .valid_i(acc), .bits_i(src_i.src_high),
                       .valid_o(v1), .half_o(h1));

  assign b0 = w3_q[7:0];
  assign b1 = w3_q[15:8];
  assign b2 = w3_q[23:16];
  assign b3 = w3_q[31:24];

  always_ff @(posedge clk_i) begin
    w1_q <= src_i.src_low;
    f1_q <= fmt_q;
    l1_q <= src_i.last_in;
    w2_q <= w1_q;
    f2_q <= f1_q;
    l2_q <= l1_q;
    w3_q <= w2_q;
    f3_q <= f2_q;
    l3_q <= l2_q;
  end

  always_comb begin
    case (f3_q)
      FMT_R8:    res_o.out_word = {8'hff, b0, b0, b0};
      FMT_RGB8:  res_o.out_word = {8'hff, b2, b1, b0};
      FMT_BGR8:  res_o.out_word = {8'hff, b0, b1, b2};
      FMT_BGRA8: res_o.out_word = {b3, b0, b1, b2};
      FMT_RG16F: res_o.out_word = {h1, h0};
      default:   res_o.out_word = w3_q;
    endcase
    res_o.last_out = l3_q;
  end

  assign done_o = v0;

  a_lanes: assert property (@(posedge clk_i) disable iff (!rst_ni) v0 == v1)
    else $error("half lanes out of step");
  a_busy_low: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> ##3 done_o) else $error("lost texel");
  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, 3)) else $error("spurious result");
endmodule

FILE: rtl/core/tuf_half_stage.sv
module tuf_half_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic [31:0]        bits_i,
  output logic               valid_o,
  output logic [15:0]        half_o
);
  import tuf_pkg::*;

  half_pre_t   pre_q;
  logic        v1_q, v2_q, v3_q;
  logic        sign2_q, zero2_q, inf2_q, sub2_q;
  logic [4:0]  exp2_q;
  logic [23:0] mant2_q;
  logic [15:0] half_q;
  logic [23:0] mant_d;
  logic [14:0] rnd;

  always_comb begin
    mant_d = pre_q.sub ? (pre_q.mant >> pre_q.shift) : {1'b0, pre_q.mant[22:0]};
  end

  assign rnd = sub2_q ? 15'((mant2_q + 24'h1000) >> 13)
                      : {exp2_q, 10'd0} + 15'((mant2_q + 24'h1000) >> 13);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pre_q   <= half_decode(bits_i);
    sign2_q <= pre_q.sign;
    zero2_q <= pre_q.zero;
    inf2_q  <= pre_q.inf;
    sub2_q  <= pre_q.sub;
    exp2_q  <= pre_q.exp;
    mant2_q <= mant_d;
    if (zero2_q) begin
      half_q <= {sign2_q, 15'd0};
    end else if (inf2_q) begin
      half_q <= {sign2_q, 15'h7c00};
    end else begin
      half_q <= {sign2_q, rnd};
    end
  end

  assign valid_o = v3_q;
  assign half_o  = half_q;
endmodule

FILE: test/texel_upload_formatter_tb.sv
`timescale 1ns / 1ps

module texel_upload_formatter_tb;
  import tuf_pkg::*;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  src_t       src_i = '0;
  logic       done;
  res_t       res_o;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [2:0] cfg_data = '0;

  int unsigned mismatch_count = 0;
  int unsigned texels_sent = 0;
  int unsigned words_checked = 0;
  logic [2:0]  active_format = FmtReset;

  texel_upload_formatter u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .src_i       (src_i),
    .done_o      (done),
    .res_o       (res_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch in %s: got %h, expected %h", what, got, want);
    mismatch_count++;
  endtask

  function automatic logic [15:0] single_to_half(input logic [31:0] bits);
    logic [15:0] sgn;
    int          ex;
    logic [31:0] man;
    sgn = {bits[31], 15'd0};
    ex  = int'(bits[30:23]) - 127 + 15;
    man = {9'd0, bits[22:0]};
    if (ex <= 0) begin
      if (ex < -10) return sgn;
      man = (man | 32'h800000) >> (1 - ex);
      return sgn | 16'((man + 32'h1000) >> 13);
    end
    if (ex >= 31) return sgn | 16'h7c00;
    return sgn | 16'((32'(ex) << 10) + ((man + 32'h1000) >> 13));
  endfunction

  function automatic res_t format_texel(input logic [2:0] fmt, input src_t s);
    res_t        r;
    logic [7:0]  b0, b1, b2, b3;
    {b3, b2, b1, b0} = s.src_low;
    case (fmt)
      FMT_R8:    r.out_word = {8'hff, b0, b0, b0};
      FMT_RGB8:  r.out_word = {8'hff, b2, b1, b0};
      FMT_BGR8:  r.out_word = {8'hff, b0, b1, b2};
      FMT_BGRA8: r.out_word = {b3, b0, b1, b2};
      FMT_RG16F: r.out_word = {single_to_half(s.src_high), single_to_half(s.src_low)};
      default:   r.out_word = s.src_low;
    endcase
    r.last_out = s.last_in;
    return r;
  endfunction

  class texel_scoreboard;
    res_t pending_words[$];

    function void note_texel(input logic [2:0] fmt, input src_t s);
      pending_words.insert(pending_words.size(), format_texel(fmt, s));
    endfunction

    task check_word(input res_t got);
      res_t want;
      if (pending_words.size() == 0) begin
        report_mismatch("unexpected result", got.out_word, '0);
        return;
      end
      want = pending_words.pop_front();
      words_checked++;
      if (got.out_word !== want.out_word)
        report_mismatch("out_word", got.out_word, want.out_word);
      if (got.last_out !== want.last_out)
        report_mismatch("last_out", 32'(got.last_out), 32'(want.last_out));
    endtask
  endclass

  texel_scoreboard sb = new();

  always @(posedge clk_i) begin
    if (rst_ni && done) sb.check_word(res_o);
  end

  task automatic idle_gap();
    int unsigned n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 2);
    repeat (n) @(negedge clk_i);
  endtask

  task automatic send_texel(input src_t s, input bit gaps);
    start <= 1'b1;
    src_i <= s;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note_texel(active_format, s);
    texels_sent++;
    @(negedge clk_i);
    if (gaps && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      idle_gap();
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending_words.size() != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  task automatic write_format(input logic [2:0] fmt);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= fmt;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    active_format = fmt;
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] random_float();
    logic [31:0] f;
    f = $urandom();
    case ($urandom_range(0, 5))
      0: f[30:23] = 8'(97 + $urandom_range(0, 20));
      1: f[30:23] = 8'(140 + $urandom_range(0, 6));
      2: f[30:23] = 8'(110 + $urandom_range(0, 34));
      3: f[12:0] = 13'h1000 + 13'($urandom_range(0, 1));
      default: ;
    endcase
    return f;
  endfunction

  function automatic src_t random_texel(input logic [2:0] fmt);
    src_t s;
    s.src_low  = $urandom();
    s.src_high = $urandom();
    s.last_in  = ($urandom_range(0, 7) == 0);
    if (fmt == FMT_RG16F) begin
      s.src_low  = random_float();
      s.src_high = random_float();
    end
    return s;
  endfunction

  localparam logic [31:0] FloatEdges[14] = '{
    32'h0000_0000, 32'h8000_0000, 32'h7f80_0000, 32'hff80_0000, 32'h7fc0_0001,
    32'h477f_efff, 32'h477f_f000, 32'h3880_0000, 32'h387f_f000, 32'h3300_0000,
    32'h32ff_ffff, 32'h3f80_1000, 32'hffff_ffff, 32'h3f7f_f000
  };

  initial begin
    logic [2:0] fmt;
    src_t       s;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset format first, then each format with its extremes.
    send_texel('{src_high: '1, src_low: 32'h8040_2001, last_in: 1'b1}, 1'b0);
    for (int f = 0; f < 8; f++) begin
      write_format(3'(f));
      if (f == FMT_RG16F) begin
        for (int k = 0; k < 14; k++)
          send_texel('{src_high: FloatEdges[13 - k], src_low: FloatEdges[k],
                       last_in: 1'(k)}, 1'b0);
      end else begin
        send_texel('{src_high: '0, src_low: '0, last_in: 1'b0}, 1'b0);
        send_texel('{src_high: '1, src_low: '1, last_in: 1'b1}, 1'b0);
        send_texel('{src_high: 32'h5555_5555, src_low: 32'h0403_0201, last_in: 1'b0}, 1'b0);
      end
    end

    for (int phase = 0; phase < 12; phase++) begin
      case (phase)
        0: fmt = FMT_R8;
        1: fmt = FMT_RG16F;
        2: fmt = 3'd7;
        default: fmt = 3'($urandom_range(0, 7));
      endcase
      write_format(fmt);
      for (int i = 0; i < 105; i++) begin
        if (i == 50) drain();
        s = random_texel(fmt);
        send_texel(s, phase % 4 != 3);
      end
    end

    drain();
    $display("Sent %0d texels over all eight format codes, checked %0d words.",
             texels_sent, words_checked);
    $display("Float conversions covered tiny, subnormal, rounding, overflow and NaN inputs.");
    if (mismatch_count == 0) begin
      $display("[texel_upload_formatter] OK");
    end else begin
      $display("[texel_upload_formatter] ERROR");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("[texel_upload_formatter] ERROR");
    $finish;
  end

endmodule
